@@ rtl/gtc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types and constants for the genotype concordance counter.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int CODE_W        = 32;   // width of one sample's slot bytes
    localparam int SLOT_BYTES    = CODE_W / 8;
    localparam int MAX_SLOTS_DEF = 4;
    localparam int ALLELE_W      = 7;    // slot byte shifted right by one
    localparam int CNT_W         = 32;
    localparam int NUM_PAIRS     = 16;
    localparam int RIDX_W        = 5;
    localparam int COUNT_W       = 3;

    localparam logic [7:0]        VEC_END    = 8'h81;
    localparam logic [RIDX_W-1:0] BIAS_INDEX = RIDX_W'(NUM_PAIRS);

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [1:0] {
        CLS_REF = 2'd0,
        CLS_HET = 2'd1,
        CLS_HOM = 2'd2,
        CLS_UNC = 2'd3
    } cls_t;

    typedef enum logic [1:0] {
        CFG_DOT_AS_REF  = 2'd0,
        CFG_EXPORT_UNC  = 2'd1,
        CFG_OUTPUT_EN   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        cls_t                cls;
        logic [ALLELE_W-1:0] lo;
        logic [ALLELE_W-1:0] hi;
    } scan_t;

endpackage
`default_nettype wire

@@ rtl/gtc_sample_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gtc_sample_scan
// Scans one sample's genotype slots and returns its class and allele range.
// ----------------------------------------------------------------------------
module gtc_sample_scan
    import gtc_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic [CODE_W-1:0]  codes,
    input  wire logic [COUNT_W-1:0] slot_count,
    input  wire logic               dot_as_ref,
    output scan_t                   result
);

    localparam int EXT_W = 8 * MAX_SLOTS;

    logic [EXT_W-1:0]    codes_ext;
    logic [7:0]          slot_byte;
    logic [ALLELE_W-1:0] cur;
    logic [ALLELE_W-1:0] prev;
    logic                running;
    logic                first;
    cls_t                cls;
    logic [ALLELE_W-1:0] lo;
    logic [ALLELE_W-1:0] hi;

    // slots past the code field read as a missing allele
    generate
        if (EXT_W > CODE_W) begin : g_pad
            assign codes_ext = {{(EXT_W - CODE_W){1'b0}}, codes};
        end else if (EXT_W == CODE_W) begin : g_same
            assign codes_ext = codes;
        end else begin : g_trunc
            assign codes_ext = codes[EXT_W-1:0];
        end
    endgenerate

    always_comb begin
        cls       = CLS_UNC;
        lo        = '0;
        hi        = '0;
        prev      = '0;
        running   = 1'b1;
        first     = 1'b1;
        slot_byte = '0;
        cur       = '0;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            slot_byte = codes_ext[8*k +: 8];
            cur       = slot_byte[7:1];
            if (running && (k < int'(slot_count)) && (slot_byte != VEC_END)) begin
                if (cur == '0) begin
                    cls = dot_as_ref ? CLS_REF : CLS_UNC;
                end else if (first || (cur == prev)) begin
                    cls = (cur > ALLELE_W'(1)) ? CLS_HOM : CLS_REF;
                end else begin
                    cls = CLS_HET;
                end
                if (first) begin
                    lo = cur;
                    hi = cur;
                end else if (cur < lo) begin
                    lo = cur;
                end else if (cur > hi) begin
                    hi = cur;
                end
                prev  = cur;
                first = 1'b0;
            end else begin
                running = 1'b0;
            end
        end
    end

    assign result.cls = cls;
    assign result.lo  = lo;
    assign result.hi  = hi;

endmodule
`default_nettype wire

@@ rtl/genotype_concordance_counter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// genotype_concordance_counter_top
// Classifies reference/test genotype pairs and keeps the concordance matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one record or counter read per transfer (s_action selects).
//   m_* channel: exactly one result per input transfer, in order.
//   cfg_*: single-cycle register writes, issued only while the block is idle.
// Path: the input register takes an item at its transfer, and the result register
//   takes it from there once the result is free. Throughput: one item per
//   cycle while m_ready is high; the scan of all slots and the
//   counter increment fit in one register stage.
// Counters are updated as the item moves into the result register, so a
//   read that follows a record sees that record counted.
// Reset (aresetn low, synchronous) clears all 17 counters, the config bits
//   and both valid flags; no clearing pass is needed.
// When m_ready is low the result holds; the input register still takes one
//   more item, after which s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module genotype_concordance_counter_top
    import gtc_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic               s_genotype_present,
    input  wire logic [COUNT_W-1:0] s_slot_count,
    input  wire logic [CODE_W-1:0]  s_ref_codes,
    input  wire logic [CODE_W-1:0]  s_test_codes,
    input  wire logic [RIDX_W-1:0]  s_read_index,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_ref_class,
    output logic [1:0]              m_test_class,
    output logic                    m_skipped,
    output logic                    m_het_range_mismatch,
    output logic                    m_export_record,
    output logic [CNT_W-1:0]        m_counter_value,

    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic               cfg_wdata
);

    // config
    logic dot_as_ref_reg;
    logic export_unc_reg;
    logic output_en_reg;

    // input register
    logic               in_valid_reg;
    logic               in_action_reg;
    logic               in_present_reg;
    logic [COUNT_W-1:0] in_count_reg;
    logic [CODE_W-1:0]  in_ref_codes_reg;
    logic [CODE_W-1:0]  in_test_codes_reg;
    logic [RIDX_W-1:0]  in_read_index_reg;

    // counters
    logic [CNT_W-1:0] pair_cnt_reg [NUM_PAIRS];
    logic [CNT_W-1:0] bias_cnt_reg;

    // result register
    logic             out_valid_reg;
    logic [1:0]       ref_class_reg,  ref_class_next;
    logic [1:0]       test_class_reg, test_class_next;
    logic             skipped_reg,    skipped_next;
    logic             mismatch_reg,   mismatch_next;
    logic             export_reg,     export_next;
    logic [CNT_W-1:0] counter_reg,    counter_next;

    scan_t ref_scan;
    scan_t test_scan;
    logic  advance;
    logic  is_count;
    logic  mismatch;
    logic  class_differs;
    logic  any_uncovered;
    logic  do_count;
    logic [3:0] pair_idx;

    gtc_sample_scan #(.MAX_SLOTS(MAX_SLOTS)) u_ref_scan (
        .codes      (in_ref_codes_reg),
        .slot_count (in_count_reg),
        .dot_as_ref (dot_as_ref_reg),
        .result     (ref_scan)
    );

    gtc_sample_scan #(.MAX_SLOTS(MAX_SLOTS)) u_test_scan (
        .codes      (in_test_codes_reg),
        .slot_count (in_count_reg),
        .dot_as_ref (dot_as_ref_reg),
        .result     (test_scan)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_as_ref_reg <= 1'b0;
            export_unc_reg <= 1'b0;
            output_en_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DOT_AS_REF: dot_as_ref_reg <= cfg_wdata;
                CFG_EXPORT_UNC: export_unc_reg <= cfg_wdata;
                CFG_OUTPUT_EN:  output_en_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg     <= s_action;
            in_present_reg    <= s_genotype_present;
            in_count_reg      <= s_slot_count;
            in_ref_codes_reg  <= s_ref_codes;
            in_test_codes_reg <= s_test_codes;
            in_read_index_reg <= s_read_index;
        end
    end

    assign is_count      = (in_action_reg == ACT_COUNT) && in_present_reg;
    assign mismatch      = (ref_scan.cls == CLS_HET) && (test_scan.cls == CLS_HET)
                           && ((ref_scan.lo != test_scan.lo) || (ref_scan.hi != test_scan.hi));
    assign class_differs = ref_scan.cls != test_scan.cls;
    assign any_uncovered = (ref_scan.cls == CLS_UNC) || (test_scan.cls == CLS_UNC);
    assign pair_idx      = {ref_scan.cls, test_scan.cls};
    assign do_count      = advance && is_count;

    always_comb begin
        ref_class_next  = '0;
        test_class_next = '0;
        skipped_next    = 1'b0;
        mismatch_next   = 1'b0;
        export_next     = 1'b0;
        counter_next    = '0;
        if (in_action_reg == ACT_READ) begin
            if (in_read_index_reg < BIAS_INDEX) begin
                counter_next = pair_cnt_reg[in_read_index_reg[3:0]];
            end else if (in_read_index_reg == BIAS_INDEX) begin
                counter_next = bias_cnt_reg;
            end
        end else if (!in_present_reg) begin
            skipped_next = 1'b1;
        end else begin
            ref_class_next  = ref_scan.cls;
            test_class_next = test_scan.cls;
            mismatch_next   = mismatch;
            export_next     = output_en_reg
                              && (mismatch
                                  || (class_differs && (!any_uncovered || export_unc_reg)));
        end
    end

    // each counter increments in place; only the read side is muxed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PAIRS; i++) begin
                pair_cnt_reg[i] <= '0;
            end
            bias_cnt_reg <= '0;
        end else if (do_count) begin
            if (mismatch) begin
                bias_cnt_reg <= bias_cnt_reg + CNT_W'(1);
            end else begin
                pair_cnt_reg[pair_idx] <= pair_cnt_reg[pair_idx] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ref_class_reg  <= ref_class_next;
            test_class_reg <= test_class_next;
            skipped_reg    <= skipped_next;
            mismatch_reg   <= mismatch_next;
            export_reg     <= export_next;
            counter_reg    <= counter_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_ref_class          = ref_class_reg;
    assign m_test_class         = test_class_reg;
    assign m_skipped            = skipped_reg;
    assign m_het_range_mismatch = mismatch_reg;
    assign m_export_record      = export_reg;
    assign m_counter_value      = counter_reg;

endmodule
`default_nettype wire

@@ bench/genotype_concordance_counter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// genotype_concordance_counter_top_tb
// Drives variant records and counter reads through the concordance counter
// with random gaps on both sides and checks every result, in order, against
// a class-pair matrix kept in the bench. Runs a directed set, then random
// records under every register setting.
// ----------------------------------------------------------------------------
module genotype_concordance_counter_top_tb;
    import gtc_pkg::*;

    localparam int    SLOTS       = MAX_SLOTS_DEF;
    localparam int    NO_ALLELE   = -2;
    localparam int    PHASE_ITEMS = 206;
    localparam int    MAX_REPORTS = 10;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic               action;
        logic               present;
        logic [COUNT_W-1:0] slot_count;
        logic [CODE_W-1:0]  ref_codes;
        logic [CODE_W-1:0]  test_codes;
        logic [RIDX_W-1:0]  read_index;
    } gt_record_t;

    typedef struct {
        logic [1:0]       ref_cls;
        logic [1:0]       test_cls;
        logic             skipped;
        logic             het_mismatch;
        logic             export_rec;
        logic [CNT_W-1:0] count_value;
    } gt_result_t;

    class concordance_scoreboard;
        logic [CNT_W-1:0] pair_count [NUM_PAIRS];
        logic [CNT_W-1:0] bias_total;
        bit               dot_as_ref;
        bit               export_unc;
        bit               output_en;
        gt_result_t       due_q [$];
        int               error_count;
        int               reported;

        function new();
            foreach (pair_count[i]) pair_count[i] = '0;
            bias_total  = '0;
            dot_as_ref  = 0;
            export_unc  = 0;
            output_en   = 0;
            error_count = 0;
            reported    = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, bit val);
            case (idx)
                CFG_DOT_AS_REF: dot_as_ref = val;
                CFG_EXPORT_UNC: export_unc = val;
                CFG_OUTPUT_EN:  output_en  = val;
                default: ;
            endcase
        endfunction

        // last scanned slot decides the class; lo/hi track the allele range
        function void scan_sample(input logic [CODE_W-1:0] codes,
                                  input logic [COUNT_W-1:0] n,
                                  output cls_t cls, output int lo, output int hi);
            int         prev;
            int         cur;
            logic [7:0] slot;
            prev = NO_ALLELE;
            cls  = CLS_UNC;
            lo   = NO_ALLELE;
            hi   = NO_ALLELE;
            for (int k = 0; k < SLOTS; k++) begin
                if (k >= n) break;
                slot = (k < SLOT_BYTES) ? codes[8*k +: 8] : 8'h00;
                if (slot == VEC_END) break;
                cur = slot[7:1];
                if (cur == 0)
                    cls = dot_as_ref ? CLS_REF : CLS_UNC;
                else if (prev == NO_ALLELE || prev == cur)
                    cls = (cur > 1) ? CLS_HOM : CLS_REF;
                else
                    cls = CLS_HET;
                if (prev == NO_ALLELE) begin
                    lo = cur;
                    hi = cur;
                end else if (cur < lo) begin
                    lo = cur;
                end else if (cur > hi) begin
                    hi = cur;
                end
                prev = cur;
            end
        endfunction

        function void note_record(gt_record_t r);
            gt_result_t e;
            cls_t       a;
            cls_t       b;
            int         alo, ahi, blo, bhi;
            e.ref_cls      = CLS_REF;
            e.test_cls     = CLS_REF;
            e.skipped      = 1'b0;
            e.het_mismatch = 1'b0;
            e.export_rec   = 1'b0;
            e.count_value  = '0;
            if (r.action == ACT_READ) begin
                if (r.read_index < NUM_PAIRS)
                    e.count_value = pair_count[r.read_index];
                else if (r.read_index == BIAS_INDEX)
                    e.count_value = bias_total;
            end else if (!r.present) begin
                e.skipped = 1'b1;
            end else begin
                scan_sample(r.ref_codes, r.slot_count, a, alo, ahi);
                scan_sample(r.test_codes, r.slot_count, b, blo, bhi);
                e.het_mismatch = (a == CLS_HET && b == CLS_HET && (alo != blo || ahi != bhi));
                if (e.het_mismatch) begin
                    bias_total   = bias_total + 1;
                    e.export_rec = output_en;
                end else begin
                    pair_count[{a, b}] = pair_count[{a, b}] + 1;
                end
                if (a != b && output_en) begin
                    if (a == CLS_UNC || b == CLS_UNC) begin
                        if (export_unc) e.export_rec = 1'b1;
                    end else begin
                        e.export_rec = 1'b1;
                    end
                end
                e.ref_cls  = a;
                e.test_cls = b;
            end
            due_q.push_back(e);
        endfunction

        function void check_result(gt_result_t got);
            gt_result_t e;
            if (due_q.size() == 0) begin
                error_count++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("result error at %0t: result with nothing pending", $realtime);
                end
                return;
            end
            e = due_q.pop_front();
            if (got.ref_cls !== e.ref_cls || got.test_cls !== e.test_cls ||
                got.skipped !== e.skipped || got.het_mismatch !== e.het_mismatch ||
                got.export_rec !== e.export_rec || got.count_value !== e.count_value) begin
                error_count++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("result error at %0t: exp cls %0d/%0d skip %0d het %0d exp %0d cnt %0d",
                             $realtime, e.ref_cls, e.test_cls, e.skipped, e.het_mismatch,
                             e.export_rec, e.count_value);
                    $display("                     got cls %0d/%0d skip %0d het %0d exp %0d cnt %0d",
                             got.ref_cls, got.test_cls, got.skipped, got.het_mismatch,
                             got.export_rec, got.count_value);
                end
            end
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic               s_genotype_present;
    logic [COUNT_W-1:0] s_slot_count;
    logic [CODE_W-1:0]  s_ref_codes;
    logic [CODE_W-1:0]  s_test_codes;
    logic [RIDX_W-1:0]  s_read_index;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_ref_class;
    logic [1:0]         m_test_class;
    logic               m_skipped;
    logic               m_het_range_mismatch;
    logic               m_export_record;
    logic [CNT_W-1:0]   m_counter_value;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic               cfg_wdata;

    concordance_scoreboard sb;
    bit                    calm;
    longint                cycle_count;

    genotype_concordance_counter_top #(.MAX_SLOTS(SLOTS)) u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_genotype_present   (s_genotype_present),
        .s_slot_count         (s_slot_count),
        .s_ref_codes          (s_ref_codes),
        .s_test_codes         (s_test_codes),
        .s_read_index         (s_read_index),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_ref_class          (m_ref_class),
        .m_test_class         (m_test_class),
        .m_skipped            (m_skipped),
        .m_het_range_mismatch (m_het_range_mismatch),
        .m_export_record      (m_export_record),
        .m_counter_value      (m_counter_value),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic gt_record_t make_item(logic act, logic pres, int n,
                                             logic [CODE_W-1:0] rc, logic [CODE_W-1:0] tc,
                                             int idx);
        gt_record_t r;
        r.action     = act;
        r.present    = pres;
        r.slot_count = COUNT_W'(n);
        r.ref_codes  = rc;
        r.test_codes = tc;
        r.read_index = RIDX_W'(idx);
        return r;
    endfunction

    // mostly small alleles so classes repeat; some vector ends and raw noise
    function automatic logic [CODE_W-1:0] random_codes();
        logic [CODE_W-1:0] c;
        int                roll;
        for (int k = 0; k < SLOT_BYTES; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                c[8*k +: 8] = {3'($urandom_range(0, 3)), 4'b0, 1'($urandom)} |
                              {1'b0, 7'($urandom_range(0, 3)) << 1} & 8'h00;
            else if (roll < 85)
                c[8*k +: 8] = {7'($urandom_range(0, 127)), 1'($urandom)};
            else if (roll < 92)
                c[8*k +: 8] = VEC_END;
            else
                c[8*k +: 8] = 8'($urandom);
            if (roll < 80)
                c[8*k +: 8] = {7'($urandom_range(0, 3)), 1'($urandom)};
        end
        return c;
    endfunction

    function automatic gt_record_t random_record();
        gt_record_t r;
        int         roll;
        logic [7:0] tmp;
        r.action     = ACT_COUNT;
        r.present    = 1'b1;
        r.slot_count = COUNT_W'($urandom_range(1, SLOTS));
        r.ref_codes  = random_codes();
        r.test_codes = random_codes();
        r.read_index = RIDX_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 18) begin
            r.action     = ACT_READ;
            r.present    = 1'($urandom);
            r.ref_codes  = $urandom;
            r.test_codes = $urandom;
            if ($urandom_range(0, 5) != 0)
                r.read_index = RIDX_W'($urandom_range(0, NUM_PAIRS));
        end else if (roll < 23) begin
            r.present   = 1'b0;
            r.ref_codes = $urandom;
        end else begin
            if ($urandom_range(0, 7) == 0)
                r.slot_count = COUNT_W'($urandom);
            roll = $urandom_range(0, 99);
            // matching and permuted copies reach the het/het range compare
            if (roll < 30) begin
                r.test_codes = r.ref_codes;
            end else if (roll < 50) begin
                r.test_codes = r.ref_codes;
                tmp = r.test_codes[7:0];
                r.test_codes[7:0]  = r.test_codes[15:8];
                r.test_codes[15:8] = tmp;
                if ($urandom_range(0, 1) == 1)
                    r.test_codes[23:16] = {7'($urandom_range(1, 4)), 1'($urandom)};
            end
        end
        return r;
    endfunction

    task automatic send_record(gt_record_t r);
        int gap;
        if ($urandom_range(0, 39) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action           = r.action;
        s_genotype_present = r.present;
        s_slot_count       = r.slot_count;
        s_ref_codes        = r.ref_codes;
        s_test_codes       = r.test_codes;
        s_read_index       = r.read_index;
        s_valid            = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_record(r);
    endtask

    // hold the sender until every pending result is back
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, bit val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(logic [2:0] s);
        write_reg(CFG_DOT_AS_REF, s[2]);
        write_reg(CFG_EXPORT_UNC, s[1]);
        write_reg(CFG_OUTPUT_EN,  s[0]);
    endtask

    // result side: random stall per result
    initial begin
        int         stall;
        gt_result_t got;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.ref_cls      = m_ref_class;
            got.test_cls     = m_test_class;
            got.skipped      = m_skipped;
            got.het_mismatch = m_het_range_mismatch;
            got.export_rec   = m_export_record;
            got.count_value  = m_counter_value;
            sb.check_result(got);
        end
    end

    initial begin
        gt_record_t directed [$];
        logic [2:0] setting_list [8];
        setting_list = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b001, 3'b110, 3'b100, 3'b011};
        cycle_count        = 0;
        calm               = 0;
        s_valid            = 1'b0;
        s_action           = ACT_COUNT;
        s_genotype_present = 1'b0;
        s_slot_count       = '0;
        s_ref_codes        = '0;
        s_test_codes       = '0;
        s_read_index       = '0;
        m_ready            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_DOT_AS_REF;
        cfg_wdata          = 1'b0;
        sb = new();
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed set with exports of uncovered pairs enabled
        apply_setting(3'b011);
        directed.push_back(make_item(ACT_READ,  1, 0, '0, '0, NUM_PAIRS));
        directed.push_back(make_item(ACT_COUNT, 0, 4, 32'h0404_0404, 32'h0202_0202, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 0, 32'h0404_0404, 32'h0202_0202, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 2, 32'h0000_0404, 32'h0000_0505, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 2, 32'h0000_0202, 32'h0000_0303, 0));
        // het/het, same range in another order
        directed.push_back(make_item(ACT_COUNT, 1, 2, 32'h0000_0402, 32'h0000_0204, 0));
        // het/het, different range: bias
        directed.push_back(make_item(ACT_COUNT, 1, 2, 32'h0000_0402, 32'h0000_0602, 0));
        // missing allele against hom
        directed.push_back(make_item(ACT_COUNT, 1, 1, 32'h0000_0000, 32'h0000_0004, 0));
        // vector end in first and second slot
        directed.push_back(make_item(ACT_COUNT, 1, 3, 32'h0002_0281, 32'h0004_8102, 0));
        // slot count past the slot limit
        directed.push_back(make_item(ACT_COUNT, 1, 7, 32'hFFFF_FFFF, 32'h0000_0000, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 5, 32'hFEFE_FEFE, 32'hFFFF_FFFF, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 6, 32'h0201_0300, 32'h0607_0302, 0));
        // het against hom and het against ref
        directed.push_back(make_item(ACT_COUNT, 1, 2, 32'h0000_0604, 32'h0000_0606, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 3, 32'h0002_0202, 32'h0004_0202, 0));
        // range with a late high allele that follows a new low
        directed.push_back(make_item(ACT_COUNT, 1, 4, 32'h0602_0804, 32'h0204_0806, 0));
        directed.push_back(make_item(ACT_COUNT, 1, 4, 32'h0802_0604, 32'h0402_0806, 0));
        directed.push_back(make_item(ACT_READ,  0, 0, '1, '1, 0));
        directed.push_back(make_item(ACT_READ,  1, 0, '0, '0, 5));
        directed.push_back(make_item(ACT_READ,  1, 0, '0, '0, 10));
        directed.push_back(make_item(ACT_READ,  1, 0, '0, '0, 15));
        directed.push_back(make_item(ACT_READ,  1, 0, '0, '0, NUM_PAIRS));
        directed.push_back(make_item(ACT_READ,  1, 0, '0, '0, 17));
        directed.push_back(make_item(ACT_READ,  1, 0, '1, '1, 31));
        foreach (directed[i]) send_record(directed[i]);
        settle();

        foreach (setting_list[p]) begin
            apply_setting(setting_list[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_record(random_record());
                if (p == 3 && i == PHASE_ITEMS / 2) settle();
            end
            settle();
        end

        repeat (8) @(posedge aclk);
        sb.error_count += sb.outstanding();
        if (sb.error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
